// ===== rtl/core/dpu_pkg.sv =====
// shared types, constants and helpers for the depth unprojection block
package dpu_pkg;

    localparam int unsigned MaxWidthDefault  = 4096;
    localparam int unsigned MaxHeightDefault = 4096;

    typedef enum logic [2:0] {
        CFG_CULL_MODE   = 3'd0,
        CFG_IMAGE_WIDTH = 3'd1,
        CFG_X_STEP      = 3'd2,
        CFG_Y_STEP      = 3'd3,
        CFG_MATRIX_0    = 3'd4,
        CFG_MATRIX_1    = 3'd5,
        CFG_MATRIX_2    = 3'd6,
        CFG_MATRIX_3    = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_DIV  = 2'd2,
        ST_OUT  = 2'd3
    } back_state_t;

    // one classified pixel handed from front to back
    typedef struct packed {
        logic        kept;
        logic        last;
        logic [16:0] depth;
        logic [23:0] index;
        logic [13:0] column;
        logic [13:0] row;
    } pix_t;

    localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
    localparam logic [31:0] SatNeg = 32'h8000_0000;

    function automatic logic signed [15:0] mat_entry(input logic [63:0] row,
                                                     input logic [1:0] col);
        mat_entry = row[16*col +: 16];
    endfunction

endpackage

// ===== rtl/core/dpu_front.sv =====
// front end: handshake, culling and raster counters
module dpu_front
#(
    parameter int unsigned MAX_WIDTH  = dpu_pkg::MaxWidthDefault,
    parameter int unsigned MAX_HEIGHT = dpu_pkg::MaxHeightDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [16:0]        depth_sample,
    input  logic               last_in_frame,
    input  logic [1:0]         cull_mode,
    input  logic [12:0]        image_width,
    output logic               q_valid,
    input  logic               q_ready,
    output dpu_pkg::pix_t      q_pix
);
    import dpu_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW:0]   col_reg, col_next;
    logic [RW:0]   row_reg, row_next;
    logic [23:0]   kept_reg, kept_next;
    logic          full_reg;
    pix_t          pix_reg;
    logic          take, cull;
    logic [CW+1:0] wid_lim;

    assign in_ready = !full_reg || q_ready;
    assign take     = in_valid && in_ready;
    assign q_valid  = full_reg;
    assign q_pix    = pix_reg;

    assign cull = (cull_mode[0] && depth_sample == 17'd0)
               || (cull_mode[1] && depth_sample[16]);

    always_comb
    begin
        if (32'(image_width) > MAX_WIDTH)
            wid_lim = (CW+2)'(MAX_WIDTH);
        else
            wid_lim = (CW+2)'(image_width);
        col_next  = col_reg;
        row_next  = row_reg;
        kept_next = cull ? kept_reg : kept_reg + 24'd1;
        if (last_in_frame)
        begin
            col_next  = '0;
            row_next  = '0;
            kept_next = '0;
        end
        else if ((CW+2)'(col_reg) + 1 >= wid_lim)
        begin
            col_next = '0;
            row_next = ((RW+1)'(row_reg) + 1 >= (RW+1)'(MAX_HEIGHT)) ? '0 : row_reg + 1'b1;
        end
        else
            col_next = col_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            kept_reg <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                kept_reg <= kept_next;
                full_reg <= 1'b1;
            end
            else if (q_ready)
                full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg.kept   <= !cull;
            pix_reg.last   <= last_in_frame;
            pix_reg.depth  <= depth_sample;
            pix_reg.index  <= kept_reg;
            pix_reg.column <= 14'(col_reg);
            pix_reg.row    <= 14'(row_reg);
        end
    end
endmodule

// ===== rtl/core/dpu_divider.sv =====
// iterative signed q16.16 divider with saturation, one quotient bit per cycle
module dpu_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               done,
    output logic [31:0]        quot
);
    import dpu_pkg::*;

    logic [63:0] d_reg, r_reg;
    logic [63:0] n_reg;
    logic [32:0] q_reg;
    logic [6:0]  cnt_reg;
    logic        neg_reg, busy_reg, ovf_reg;
    logic [64:0] r_sh, r_sub;
    logic        ge;

    assign r_sub = r_sh - {1'b0, d_reg};
    assign ge    = !r_sub[64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd79)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // long division over 64 integer bits and 16 fraction bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[63] != den[63];
            r_reg   <= '0;
            d_reg   <= den[63] ? -den : den;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            n_reg   <= num[63] ? -num : num;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[62:0], 1'b0};
            if (ge)
                r_reg <= r_sub[63:0];
            else
                r_reg <= r_sh[63:0];
            q_reg <= {q_reg[31:0], ge};
            if (q_reg[32])
                ovf_reg <= 1'b1;
        end
    end

    always_comb
    begin
        r_sh = {r_reg, n_reg[63]};
    end

    always_comb
    begin
        if (ovf_reg || q_reg[32])
            quot = neg_reg ? SatNeg : SatPos;
        else if (neg_reg)
            quot = (q_reg[31:0] > 32'h8000_0000) ? SatNeg : 32'd0 - q_reg[31:0];
        else
            quot = q_reg[31] ? SatPos : q_reg[31:0];
    end
endmodule

// ===== rtl/core/dpu_back.sv =====
// back end: view vector, matrix products, perspective divide, output register
module dpu_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  dpu_pkg::pix_t      q_pix,
    input  logic [31:0]        x_step,
    input  logic [31:0]        y_step,
    input  logic [63:0]        mrow0,
    input  logic [63:0]        mrow1,
    input  logic [63:0]        mrow2,
    input  logic [63:0]        mrow3,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic               point_kept,
    output logic [23:0]        point_index,
    output logic               w_invalid,
    output logic               frame_end
);
    import dpu_pkg::*;

    back_state_t st_reg, st_next;
    pix_t        p_reg;
    logic [2:0]  step_reg;
    logic signed [47:0] v_reg [4];
    logic signed [63:0] acc_reg [4];
    logic [1:0]  comp_reg, comp_next;
    logic signed [63:0] prod;
    logic signed [63:0] vv;
    logic signed [15:0] e;
    logic [63:0] mrow;
    logic        dstart, ddone;
    logic [31:0] dq;
    logic signed [31:0] res_reg [3];
    logic        winv_reg;
    logic        load, obusy;

    dpu_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (acc_reg[comp_next]),
        .den   (acc_reg[3]),
        .done  (ddone),
        .quot  (dq)
    );

    assign q_ready = (st_reg == ST_IDLE);
    assign load    = q_valid && q_ready;

    // view vector lanes are formed at load; steps 0..15 accumulate (row, col) products
    always_comb
    begin
        mrow = mrow0;
        case (step_reg[1:0])
            2'd0: mrow = mrow0;
            2'd1: mrow = mrow1;
            2'd2: mrow = mrow2;
            default: mrow = mrow3;
        endcase
        e    = mat_entry(mrow, comp_reg);
        vv   = 64'(v_reg[comp_reg]);
        prod = 64'(e) * vv;
    end

    logic [4:0] mcnt_reg;

    always_comb
    begin
        st_next   = st_reg;
        comp_next = comp_reg;
        dstart    = 1'b0;
        case (st_reg)
            ST_IDLE:
                if (load)
                    st_next = ST_MUL;
            ST_MUL:
                if (mcnt_reg == 5'd17)
                begin
                    if (!p_reg.kept || acc_reg[3] == 64'sd0)
                        st_next = ST_OUT;
                    else
                    begin
                        st_next   = ST_DIV;
                        comp_next = 2'd0;
                        dstart    = 1'b1;
                    end
                end
            ST_DIV:
                if (ddone)
                begin
                    if (comp_reg == 2'd2)
                        st_next = ST_OUT;
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                        dstart    = 1'b1;
                    end
                end
            default:
                if (!obusy)
                    st_next = ST_IDLE;
        endcase
    end

    assign obusy = out_valid && !out_ready;

    function automatic logic signed [31:0] sgn_sat(input logic signed [63:0] n);
        if (n > 0)
            sgn_sat = SatPos;
        else if (n < 0)
            sgn_sat = SatNeg;
        else
            sgn_sat = '0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_OUT && !obusy)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_reg    <= q_pix;
            mcnt_reg <= 5'd0;
            v_reg[0] <= 48'(signed'({1'b0, x_step}) * signed'({1'b0, q_pix.column}))
                      - 48'sd1073741824;
            v_reg[1] <= 48'(signed'({1'b0, y_step}) * signed'({1'b0, q_pix.row}))
                      - 48'sd1073741824;
            v_reg[2] <= 48'({q_pix.depth, 14'd0});
            v_reg[3] <= 48'sd1073741824;
            for (int i = 0; i < 4; i++)
                acc_reg[i] <= '0;
            comp_reg <= 2'd0;
            step_reg <= 3'd0;
            winv_reg <= 1'b0;
        end
        else if (st_reg == ST_MUL)
        begin
            mcnt_reg <= mcnt_reg + 5'd1;
            if (mcnt_reg < 5'd16)
            begin
                acc_reg[step_reg[1:0]] <= acc_reg[step_reg[1:0]] + prod;
                step_reg <= step_reg + 3'd1;
                if (step_reg[1:0] == 2'd3)
                    comp_reg <= comp_reg + 2'd1;
            end
            if (mcnt_reg == 5'd17)
            begin
                winv_reg   <= p_reg.kept && acc_reg[3] == 64'sd0;
                res_reg[0] <= p_reg.kept ? sgn_sat(acc_reg[0]) : '0;
                res_reg[1] <= p_reg.kept ? sgn_sat(acc_reg[1]) : '0;
                res_reg[2] <= p_reg.kept ? sgn_sat(acc_reg[2]) : '0;
            end
        end
        else if (st_reg == ST_DIV && ddone)
        begin
            res_reg[comp_reg] <= dq;
            comp_reg          <= comp_next;
        end
        if (st_reg == ST_OUT && !obusy)
        begin
            point_x     <= res_reg[0];
            point_y     <= res_reg[1];
            point_z     <= res_reg[2];
            point_kept  <= p_reg.kept;
            point_index <= p_reg.kept ? p_reg.index : '0;
            w_invalid   <= winv_reg;
            frame_end   <= p_reg.last;
        end
    end
endmodule

// ===== rtl/core/depth_pixel_unprojection.sv =====
// top level of the depth pixel unprojection block
// a kept pixel with non-zero w passes the product steps, then three long divisions in the
// shared divider; a culled pixel or one with zero w skips the divisions
// one pixel in the back end at a time, and no new one is taken until its result is registered;
// the front register takes the next pixel meanwhile; result stalls hold the back end
// reset: counters clear, cull_mode 2, image_width 640, steps and matrix zero
module depth_pixel_unprojection
#(
    parameter int unsigned MAX_WIDTH  = dpu_pkg::MaxWidthDefault,
    parameter int unsigned MAX_HEIGHT = dpu_pkg::MaxHeightDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [16:0]        depth_sample,
    input  logic               last_in_frame,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic               point_kept,
    output logic [23:0]        point_index,
    output logic               w_invalid,
    output logic               frame_end,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import dpu_pkg::*;

    // configuration registers
    logic [1:0]  cull_reg;
    logic [12:0] width_reg;
    logic [31:0] xstep_reg, ystep_reg;
    logic [63:0] m_reg [4];

    // queue slot between front and back
    logic q_valid, q_ready;
    pix_t q_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cull_reg  <= 2'd2;
            width_reg <= 13'd640;
            xstep_reg <= '0;
            ystep_reg <= '0;
            for (int i = 0; i < 4; i++)
                m_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CULL_MODE:   cull_reg  <= cfg_data[1:0];
                CFG_IMAGE_WIDTH: width_reg <= cfg_data[12:0];
                CFG_X_STEP:      xstep_reg <= cfg_data[31:0];
                CFG_Y_STEP:      ystep_reg <= cfg_data[31:0];
                CFG_MATRIX_0:    m_reg[0]  <= cfg_data;
                CFG_MATRIX_1:    m_reg[1]  <= cfg_data;
                CFG_MATRIX_2:    m_reg[2]  <= cfg_data;
                default:         m_reg[3]  <= cfg_data;
            endcase
        end
    end

    // front: culling decision, raster and dense index counters
    dpu_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .depth_sample  (depth_sample),
        .last_in_frame (last_in_frame),
        .cull_mode     (cull_reg),
        .image_width   (width_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_pix         (q_pix)
    );

    // back: matrix products and perspective divide
    dpu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_pix       (q_pix),
        .x_step      (xstep_reg),
        .y_step      (ystep_reg),
        .mrow0       (m_reg[0]),
        .mrow1       (m_reg[1]),
        .mrow2       (m_reg[2]),
        .mrow3       (m_reg[3]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_kept  (point_kept),
        .point_index (point_index),
        .w_invalid   (w_invalid),
        .frame_end   (frame_end)
    );
endmodule

// ===== bench/depth_pixel_unprojection_check.sv =====
// checker: watches both channels and the register port, predicts each point and compares
module depth_pixel_unprojection_check
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [16:0]        depth_sample,
    input  logic               last_in_frame,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               point_kept,
    input  logic [23:0]        point_index,
    input  logic               w_invalid,
    input  logic               frame_end,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output int                 errors,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import dpu_pkg::*;

    localparam int unsigned WidthCap  = 4096;
    localparam int unsigned HeightCap = 4096;
    localparam longint      OneQ30    = 64'sd1 << 30;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        kept;
        logic [23:0] index;
        logic        winv;
        logic        fend;
    } point_t;

    point_t      points_due[$];
    logic [1:0]  cull_mode;
    logic [12:0] image_width;
    logic [31:0] x_step;
    logic [31:0] y_step;
    logic [63:0] matrix[4];
    int unsigned column;
    int unsigned row;
    logic [23:0] kept_count;

    function automatic longint row_dot(logic [63:0] mrow, longint v0, longint v1,
                                       longint v2, longint v3);
        longint acc;
        acc = longint'($signed(mrow[15:0]))  * v0 + longint'($signed(mrow[31:16])) * v1
            + longint'($signed(mrow[47:32])) * v2 + longint'($signed(mrow[63:48])) * v3;
        return acc;
    endfunction

    function automatic logic [31:0] sign_sat(longint num);
        return num > 0 ? SatPos : (num < 0 ? SatNeg : 32'd0);
    endfunction

    // num/den in q16.16, truncated toward zero, saturated
    function automatic logic [31:0] quotient_q16(longint num, longint den);
        bit       neg;
        bit [63:0] n;
        bit [63:0] d;
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] mag;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        if (q >= 64'd65536)
            return neg ? SatNeg : SatPos;
        mag = q;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            mag = mag << 1;
            if (r >= d)
            begin
                r = r - d;
                mag[0] = 1'b1;
            end
        end
        if (neg)
            return mag > 64'h8000_0000 ? SatNeg : 32'd0 - mag[31:0];
        return mag > 64'h7FFF_FFFF ? SatPos : mag[31:0];
    endfunction

    function automatic point_t unproject(logic [16:0] depth, logic last);
        point_t p;
        longint vx;
        longint vy;
        longint vz;
        longint nx;
        longint ny;
        longint nz;
        longint w;
        bit     cull;
        cull = (cull_mode[0] && depth == 17'd0) || (cull_mode[1] && depth >= 17'd65536);
        p = '0;
        p.fend = last;
        if (!cull)
        begin
            vx = longint'(x_step) * longint'(column) - OneQ30;
            vy = longint'(y_step) * longint'(row) - OneQ30;
            vz = longint'(depth) << 14;
            nx = row_dot(matrix[0], vx, vy, vz, OneQ30);
            ny = row_dot(matrix[1], vx, vy, vz, OneQ30);
            nz = row_dot(matrix[2], vx, vy, vz, OneQ30);
            w  = row_dot(matrix[3], vx, vy, vz, OneQ30);
            p.kept  = 1'b1;
            p.index = kept_count;
            if (w == 0)
            begin
                p.winv = 1'b1;
                p.x = sign_sat(nx);
                p.y = sign_sat(ny);
                p.z = sign_sat(nz);
            end
            else
            begin
                p.x = quotient_q16(nx, w);
                p.y = quotient_q16(ny, w);
                p.z = quotient_q16(nz, w);
            end
        end
        return p;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s expected %h actual %h", name, want, got);
            errors++;
        end
    endtask

    // all sampling on the falling edge, where the values that the next rising edge
    // acts on are settled
    always @(negedge clk or negedge rst_n)
    begin
        point_t      p;
        int unsigned wrap;
        if (!rst_n)
        begin
            points_due.delete();
            cull_mode   = 2'd2;
            image_width = 13'd640;
            x_step      = '0;
            y_step      = '0;
            for (int i = 0; i < 4; i++)
                matrix[i] = '0;
            column      = 0;
            row         = 0;
            kept_count  = '0;
            errors      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CULL_MODE:   cull_mode   = cfg_data[1:0];
                    CFG_IMAGE_WIDTH: image_width = cfg_data[12:0];
                    CFG_X_STEP:      x_step      = cfg_data[31:0];
                    CFG_Y_STEP:      y_step      = cfg_data[31:0];
                    CFG_MATRIX_0:    matrix[0]   = cfg_data;
                    CFG_MATRIX_1:    matrix[1]   = cfg_data;
                    CFG_MATRIX_2:    matrix[2]   = cfg_data;
                    CFG_MATRIX_3:    matrix[3]   = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (points_due.size() == 0)
                begin
                    $error("point transaction with nothing expected");
                    errors++;
                end
                else
                begin
                    p = points_due.pop_front();
                    check_field("point_x", p.x, point_x);
                    check_field("point_y", p.y, point_y);
                    check_field("point_z", p.z, point_z);
                    check_field("point_kept", p.kept, point_kept);
                    check_field("point_index", p.index, point_index);
                    check_field("w_invalid", p.winv, w_invalid);
                    check_field("frame_end", p.fend, frame_end);
                end
            end
            if (in_valid && in_ready)
            begin
                p = unproject(depth_sample, last_in_frame);
                points_due.push_back(p);
                if (p.kept)
                    kept_count = kept_count + 24'd1;
                wrap = image_width > WidthCap ? WidthCap : image_width;
                if (last_in_frame)
                begin
                    column = 0;
                    row = 0;
                    kept_count = '0;
                end
                else if (column + 1 >= wrap)
                begin
                    column = 0;
                    row = row + 1 >= HeightCap ? 0 : row + 1;
                end
                else
                    column++;
            end
        end
        outstanding = points_due.size();
    end

endmodule

// ===== bench/depth_pixel_unprojection_test.sv =====
// testbench top: register set-up, pixel stimulus with random idling, and the verdict
module depth_pixel_unprojection_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dpu_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [16:0]        depth_sample;
    logic               last_in_frame;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               point_kept;
    logic [23:0]        point_index;
    logic               w_invalid;
    logic               frame_end;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    int                 errors;
    int                 outstanding;
    bit                 quiet;       // no idling on either side
    bit                 stream_done;

    depth_pixel_unprojection u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .depth_sample  (depth_sample),
        .last_in_frame (last_in_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .point_kept    (point_kept),
        .point_index   (point_index),
        .w_invalid     (w_invalid),
        .frame_end     (frame_end),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    depth_pixel_unprojection_check u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .depth_sample  (depth_sample),
        .last_in_frame (last_in_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .point_kept    (point_kept),
        .point_index   (point_index),
        .w_invalid     (w_invalid),
        .frame_end     (frame_end),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // watchdog: about 1900 pixels with stalls must finish before it fires
    initial
    begin
        #40ms;
        $display("status: fail");
        $finish;
    end

    // receiver: ready in random runs, broken by stall bursts unless quiet is set
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(40, 1)) @(posedge clk);
            if (!quiet && $urandom_range(2, 0) != 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(7, 1)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // one pixel transaction; returns at the edge where it is taken, or after a random idle gap
    task automatic send_pixel(logic [16:0] depth, logic last);
        in_valid      <= 1'b1;
        depth_sample  <= depth;
        last_in_frame <= last;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        if (!quiet && $urandom_range(5, 0) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
    endtask

    // matrix row in q2.13: plain random, small entries, or all zero
    function automatic logic [63:0] pick_row(int kind);
        logic [63:0] r;
        case (kind)
            0: r = {$urandom, $urandom};
            1: for (int c = 0; c < 4; c++)
                   r[16*c +: 16] = 16'($signed($urandom_range(8192, 0)) - 4096);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] pick_depth();
        case ($urandom_range(9, 0))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom);
            3: return 17'd65535;
            default: return 17'($urandom_range(65535, 1));
        endcase
    endfunction

    // block is idle once every point is back and the divider has drained
    task automatic settle();
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (130) @(posedge clk);
    endtask

    initial
    begin
        logic [12:0] width;
        logic [63:0] w_row;
        int          frame_len;
        int          run;
        in_valid      = 1'b0;
        depth_sample  = '0;
        last_in_frame = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_CULL_MODE;
        cfg_data      = '0;
        quiet         = 1'b0;
        stream_done   = 1'b0;
        rst_n         = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero matrix, so every kept point has zero w
        send_pixel(17'd0, 1'b0);
        send_pixel(17'd65536, 1'b0);
        send_pixel(17'd1234, 1'b1);
        settle();

        // directed: identity-like camera, both culls, width 2, depth extremes
        write_reg(CFG_CULL_MODE, 64'd3);
        write_reg(CFG_IMAGE_WIDTH, 64'd2);
        write_reg(CFG_X_STEP, 64'h8000_0000);
        write_reg(CFG_Y_STEP, 64'hFFFF_FFFF);
        write_reg(CFG_MATRIX_0, 64'h0000_0000_0000_2000);
        write_reg(CFG_MATRIX_1, 64'h0000_0000_2000_0000);
        write_reg(CFG_MATRIX_2, 64'h0000_2000_0000_0000);
        write_reg(CFG_MATRIX_3, 64'h2000_E000_0000_0000);
        cfg_we <= 1'b0;
        send_pixel(17'd0, 1'b0);          // near, culled
        send_pixel(17'd65536, 1'b0);      // far, culled
        send_pixel(17'h1FFFF, 1'b0);      // above one, culled
        send_pixel(17'd65535, 1'b0);
        send_pixel(17'd1, 1'b0);
        send_pixel(17'd32768, 1'b0);      // mid depth
        send_pixel(17'h0AAAA, 1'b0);
        send_pixel(17'h15555, 1'b1);      // end of frame, culled
        send_pixel(17'd40000, 1'b0);
        send_pixel(17'd100, 1'b1);
        settle();

        // depths above one kept; width of one ends every row
        write_reg(CFG_CULL_MODE, 64'd0);
        write_reg(CFG_IMAGE_WIDTH, 64'd1);
        write_reg(CFG_MATRIX_3, 64'h7FFF_8000_7FFF_8000);
        cfg_we <= 1'b0;
        send_pixel(17'd0, 1'b0);
        send_pixel(17'h1FFFF, 1'b0);
        send_pixel(17'd65536, 1'b0);
        send_pixel(17'd77, 1'b0);
        send_pixel(17'd50000, 1'b1);
        settle();

        // random phases, each with fresh registers; the last with no idling at all
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       width = 13'd0;
                1:       width = 13'd8191;        // clamps to the widest row
                2:       width = 13'd4096;
                3:       width = 13'd2;
                default: width = 13'($urandom_range(12, 2));
            endcase
            w_row = pick_row($urandom_range(2, 0));
            if (phase == 5)
                w_row = '0;
            write_reg(CFG_CULL_MODE, 64'(phase % 4));
            write_reg(CFG_IMAGE_WIDTH, 64'(width));
            write_reg(CFG_X_STEP, phase == 6 ? 64'h0 : 64'(phase == 7 ? 32'hFFFF_FFFF : $urandom));
            write_reg(CFG_Y_STEP, phase == 6 ? 64'hFFFF_FFFF : 64'($urandom));
            write_reg(CFG_MATRIX_0, pick_row(phase % 2));
            write_reg(CFG_MATRIX_1, pick_row(1));
            write_reg(CFG_MATRIX_2, pick_row($urandom_range(1, 0)));
            write_reg(CFG_MATRIX_3, w_row);
            cfg_we <= 1'b0;
            quiet = (phase == 7);
            // mostly whole small frames, now and then an early end of frame
            run = 0;
            frame_len = $urandom_range(40, 4);
            for (int n = 0; n < 235; n++)
            begin
                run++;
                if (run >= frame_len || $urandom_range(60, 0) == 0)
                begin
                    send_pixel(pick_depth(), 1'b1);
                    run = 0;
                    frame_len = $urandom_range(40, 4);
                end
                else
                    send_pixel(pick_depth(), 1'b0);
            end
            settle();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dpu_pkg.sv
rtl/core/dpu_front.sv
rtl/core/dpu_divider.sv
rtl/core/dpu_back.sv
rtl/core/depth_pixel_unprojection.sv
bench/depth_pixel_unprojection_check.sv
bench/depth_pixel_unprojection_test.sv
